// ===== rtl/pib_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_pkg
// Shared constants, register codes and the configuration bundle for the
// particle integrate, wall bound and binning pipeline.
// ----------------------------------------------------------------------------
package pib_pkg;

   // grid binning and wall clearance
   localparam int CELL_SHIFT = 12;
   localparam int GRID_COLS  = 64;
   localparam int EDGE_EPS   = 1;

   localparam logic [15:0]        GRID_COLS_W = 16'(GRID_COLS);
   localparam logic signed [33:0] EDGE_EPS_W  = 34'(EDGE_EPS);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TIME_STEP      = 3'd0,
      REG_MAX_SPEED      = 3'd1,
      REG_ATTENUATION    = 3'd2,
      REG_SUPPORT_RADIUS = 3'd3,
      REG_BOX_LOW_X      = 3'd4,
      REG_BOX_LOW_Y      = 3'd5,
      REG_BOX_HIGH_X     = 3'd6,
      REG_BOX_HIGH_Y     = 3'd7
   } csr_index_type;

   localparam logic [16:0]        RST_TIME_STEP      = 17'd655;
   localparam logic [30:0]        RST_MAX_SPEED      = 31'd655360;
   localparam logic [16:0]        RST_ATTENUATION    = 17'd58982;
   localparam logic [30:0]        RST_SUPPORT_RADIUS = 31'd1638;
   localparam logic signed [31:0] RST_BOX_LOW_X      = 32'sd0;
   localparam logic signed [31:0] RST_BOX_LOW_Y      = 32'sd0;
   localparam logic signed [31:0] RST_BOX_HIGH_X     = 32'sd65536;
   localparam logic signed [31:0] RST_BOX_HIGH_Y     = 32'sd65536;

   // register values plus the wall and clamp bounds derived from them
   typedef struct packed {
      logic [16:0]        time_step;
      logic [30:0]        max_speed;
      logic [16:0]        attenuation;
      logic signed [31:0] box_low_x;
      logic signed [31:0] box_low_y;
      logic signed [32:0] wall_low_x;
      logic signed [32:0] wall_low_y;
      logic signed [32:0] wall_high_x;
      logic signed [32:0] wall_high_y;
      logic signed [33:0] clamp_low_x;
      logic signed [33:0] clamp_low_y;
      logic signed [33:0] clamp_high_x;
      logic signed [33:0] clamp_high_y;
   } cfg_type;

endpackage

// ===== rtl/particle_integrate_bound_bin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_integrate_bound_bin
// Q16.16 particle step: velocity and position update, wall reflection with
// attenuation, box clamp and grid cell index.
// ----------------------------------------------------------------------------
// Takes one particle per cycle as long as the result side does not hold a
// full pipeline. An accepted item moves through the stage registers in order
// and is offered on the response side from the last one. The work runs
// through an 8 stage pipeline built around three pairs of 32x18 multipliers
// (dt*acc, dt*vel, and the attenuation scale, one of each per axis), each
// followed by a register; every stage has its own valid bit and load enable,
// so stalls on the result side fill bubbles first and the request side only
// stops once every stage holds an item. Register writes through the csr port
// reach the pipeline through the csr registers and then the registered cfg bundle,
// and must only happen while no item is in flight.
module particle_integrate_bound_bin (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_vel_x,
   input  logic signed [31:0]                req_vel_y,
   input  logic signed [31:0]                req_acc_x,
   input  logic signed [31:0]                req_acc_y,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_new_pos_x,
   output logic signed [31:0]                rsp_new_pos_y,
   output logic signed [31:0]                rsp_new_vel_x,
   output logic signed [31:0]                rsp_new_vel_y,
   output logic [15:0]                       rsp_cell_index,
   output logic                              rsp_wall_hit,

   input  logic                              csr_wr_en,
   input  logic [pib_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pib_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NUM_STAGES = 8;

   pib_pkg::cfg_type cfg;

   logic [NUM_STAGES:1]   vld_ff;
   logic [NUM_STAGES+1:1] stage_en;

   // stage 1: dt * acc
   logic signed [31:0] s1_pos_x_ff, s1_pos_y_ff, s1_vel_x_ff, s1_vel_y_ff;
   logic signed [49:0] s1_dva_x_ff, s1_dva_y_ff;
   // stage 2: velocity update and clamp
   logic signed [31:0] s2_pos_x_ff, s2_pos_y_ff, s2_vel_x_ff, s2_vel_y_ff;
   logic signed [49:0] s2_sum_x, s2_sum_y;
   // stage 3: dt * vel
   logic signed [31:0] s3_pos_x_ff, s3_pos_y_ff, s3_vel_x_ff, s3_vel_y_ff;
   logic signed [49:0] s3_dvp_x_ff, s3_dvp_y_ff;
   // stage 4: position update
   logic signed [33:0] s4_pos_x_ff, s4_pos_y_ff;
   logic signed [31:0] s4_vel_x_ff, s4_vel_y_ff;
   logic signed [49:0] s4_sum_x, s4_sum_y;
   // stage 5: wall tests and reflection
   logic               lo_hit_x, lo_hit_y, hi_hit_x, hi_hit_y;
   logic signed [31:0] abs_x, abs_y;
   logic signed [31:0] s5_vel_x_in, s5_vel_y_in;
   logic signed [31:0] s5_vel_x_ff, s5_vel_y_ff;
   logic signed [33:0] s5_pmin_x_ff, s5_pmin_y_ff;
   logic               s5_hit_ff;
   // stage 6: attenuation product and lower clamp
   logic signed [49:0] s6_dvw_x_ff, s6_dvw_y_ff;
   logic signed [31:0] s6_vel_x_ff, s6_vel_y_ff;
   logic signed [31:0] s6_np_x_ff, s6_np_y_ff;
   logic               s6_hit_ff;
   // stage 7: final velocity clamp and cell coordinates
   logic signed [31:0] s7_vel_x_ff, s7_vel_y_ff;
   logic signed [31:0] s7_np_x_ff, s7_np_y_ff;
   logic [15:0]        s7_col_ff, s7_row_ff;
   logic               s7_hit_ff;
   logic signed [49:0] s7_vsel_x, s7_vsel_y;
   logic signed [32:0] s7_dx, s7_dy;
   logic signed [32:0] s7_cx, s7_cy;
   // stage 8: output register
   logic signed [31:0] s8_np_x_ff, s8_np_y_ff, s8_vel_x_ff, s8_vel_y_ff;
   logic [15:0]        s8_idx_ff;
   logic               s8_hit_ff;

   function automatic logic signed [31:0] clamp_ms(input logic signed [49:0] val,
                                                   input logic [30:0] ms);
      logic signed [49:0] lim;
      logic signed [49:0] neg;
      lim = $signed({19'd0, ms});
      neg = -lim;
      if (val > lim) begin
         clamp_ms = lim[31:0];
      end else if (val < neg) begin
         clamp_ms = neg[31:0];
      end else begin
         clamp_ms = val[31:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] val);
      if (val > 34'sh0_7FFF_FFFF) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (val < -34'sh0_8000_0000) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = val[31:0];
      end
   endfunction

   pib_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a stage loads when it is empty or its item moves on
   always_comb begin
      stage_en[NUM_STAGES+1] = rsp_ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_ready = stage_en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_pos_x_ff <= req_pos_x;
         s1_pos_y_ff <= req_pos_y;
         s1_vel_x_ff <= req_vel_x;
         s1_vel_y_ff <= req_vel_y;
         s1_dva_x_ff <= req_acc_x * $signed({1'b0, cfg.time_step});
         s1_dva_y_ff <= req_acc_y * $signed({1'b0, cfg.time_step});
      end
   end

   // stage 2
   assign s2_sum_x = 50'(s1_vel_x_ff) + (s1_dva_x_ff >>> 16);
   assign s2_sum_y = 50'(s1_vel_y_ff) + (s1_dva_y_ff >>> 16);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_pos_x_ff <= s1_pos_x_ff;
         s2_pos_y_ff <= s1_pos_y_ff;
         s2_vel_x_ff <= clamp_ms(s2_sum_x, cfg.max_speed);
         s2_vel_y_ff <= clamp_ms(s2_sum_y, cfg.max_speed);
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_pos_x_ff <= s2_pos_x_ff;
         s3_pos_y_ff <= s2_pos_y_ff;
         s3_vel_x_ff <= s2_vel_x_ff;
         s3_vel_y_ff <= s2_vel_y_ff;
         s3_dvp_x_ff <= s2_vel_x_ff * $signed({1'b0, cfg.time_step});
         s3_dvp_y_ff <= s2_vel_y_ff * $signed({1'b0, cfg.time_step});
      end
   end

   // stage 4
   assign s4_sum_x = 50'(s3_pos_x_ff) + (s3_dvp_x_ff >>> 16);
   assign s4_sum_y = 50'(s3_pos_y_ff) + (s3_dvp_y_ff >>> 16);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_pos_x_ff <= s4_sum_x[33:0];
         s4_pos_y_ff <= s4_sum_y[33:0];
         s4_vel_x_ff <= s3_vel_x_ff;
         s4_vel_y_ff <= s3_vel_y_ff;
      end
   end

   // stage 5: the high wall takes priority and so decides the sign
   always_comb begin
      lo_hit_x    = s4_pos_x_ff < cfg.wall_low_x;
      lo_hit_y    = s4_pos_y_ff < cfg.wall_low_y;
      hi_hit_x    = s4_pos_x_ff > cfg.wall_high_x;
      hi_hit_y    = s4_pos_y_ff > cfg.wall_high_y;
      abs_x       = s4_vel_x_ff[31] ? -s4_vel_x_ff : s4_vel_x_ff;
      abs_y       = s4_vel_y_ff[31] ? -s4_vel_y_ff : s4_vel_y_ff;
      s5_vel_x_in = hi_hit_x ? -abs_x : (lo_hit_x ? abs_x : s4_vel_x_ff);
      s5_vel_y_in = hi_hit_y ? -abs_y : (lo_hit_y ? abs_y : s4_vel_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_vel_x_ff  <= s5_vel_x_in;
         s5_vel_y_ff  <= s5_vel_y_in;
         s5_hit_ff    <= lo_hit_x || lo_hit_y || hi_hit_x || hi_hit_y;
         s5_pmin_x_ff <= (s4_pos_x_ff < cfg.clamp_high_x) ? s4_pos_x_ff : cfg.clamp_high_x;
         s5_pmin_y_ff <= (s4_pos_y_ff < cfg.clamp_high_y) ? s4_pos_y_ff : cfg.clamp_high_y;
      end
   end

   // stage 6: lower bound wins on an inverted box
   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_dvw_x_ff <= s5_vel_x_ff * $signed({1'b0, cfg.attenuation});
         s6_dvw_y_ff <= s5_vel_y_ff * $signed({1'b0, cfg.attenuation});
         s6_vel_x_ff <= s5_vel_x_ff;
         s6_vel_y_ff <= s5_vel_y_ff;
         s6_hit_ff   <= s5_hit_ff;
         s6_np_x_ff  <= sat32((cfg.clamp_low_x > s5_pmin_x_ff) ? cfg.clamp_low_x
                                                               : s5_pmin_x_ff);
         s6_np_y_ff  <= sat32((cfg.clamp_low_y > s5_pmin_y_ff) ? cfg.clamp_low_y
                                                               : s5_pmin_y_ff);
      end
   end

   // stage 7
   always_comb begin
      s7_vsel_x = s6_hit_ff ? (s6_dvw_x_ff >>> 16) : 50'(s6_vel_x_ff);
      s7_vsel_y = s6_hit_ff ? (s6_dvw_y_ff >>> 16) : 50'(s6_vel_y_ff);
      s7_dx     = 33'(s6_np_x_ff) - 33'(cfg.box_low_x);
      s7_dy     = 33'(s6_np_y_ff) - 33'(cfg.box_low_y);
      s7_cx     = s7_dx >>> pib_pkg::CELL_SHIFT;
      s7_cy     = s7_dy >>> pib_pkg::CELL_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_vel_x_ff <= clamp_ms(s7_vsel_x, cfg.max_speed);
         s7_vel_y_ff <= clamp_ms(s7_vsel_y, cfg.max_speed);
         s7_np_x_ff  <= s6_np_x_ff;
         s7_np_y_ff  <= s6_np_y_ff;
         s7_hit_ff   <= s6_hit_ff;
         s7_col_ff   <= s7_cx[15:0];
         s7_row_ff   <= s7_cy[15:0];
      end
   end

   // stage 8: cell index wraps modulo 2^16
   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s8_np_x_ff  <= s7_np_x_ff;
         s8_np_y_ff  <= s7_np_y_ff;
         s8_vel_x_ff <= s7_vel_x_ff;
         s8_vel_y_ff <= s7_vel_y_ff;
         s8_hit_ff   <= s7_hit_ff;
         s8_idx_ff   <= s7_row_ff * pib_pkg::GRID_COLS_W + s7_col_ff;
      end
   end

   assign rsp_valid      = vld_ff[NUM_STAGES];
   assign rsp_new_pos_x  = s8_np_x_ff;
   assign rsp_new_pos_y  = s8_np_y_ff;
   assign rsp_new_vel_x  = s8_vel_x_ff;
   assign rsp_new_vel_y  = s8_vel_y_ff;
   assign rsp_cell_index = s8_idx_ff;
   assign rsp_wall_hit   = s8_hit_ff;

`ifndef NO_ASSERTIONS
   // input side only stalls when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (vld_ff == '1) && !rsp_ready)
      else $error("request stalled with a free pipeline stage");

   // final velocity always within the speed limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_vel_x <= $signed({1'b0, cfg.max_speed}))
                 && (rsp_new_vel_x >= -$signed({1'b0, cfg.max_speed})))
      else $error("new_vel_x outside max_speed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_vel_y <= $signed({1'b0, cfg.max_speed}))
                 && (rsp_new_vel_y >= -$signed({1'b0, cfg.max_speed})))
      else $error("new_vel_y outside max_speed");
`endif

endmodule

// ===== rtl/pib_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_csr
// Configuration registers and registered wall / clamp bounds derived from
// the box and the support radius.
// ----------------------------------------------------------------------------
module pib_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pib_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pib_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output pib_pkg::cfg_type                      cfg
);

   logic [16:0]        time_step_ff;
   logic [30:0]        max_speed_ff;
   logic [16:0]        attenuation_ff;
   logic [30:0]        support_radius_ff;
   logic signed [31:0] box_low_x_ff;
   logic signed [31:0] box_low_y_ff;
   logic signed [31:0] box_high_x_ff;
   logic signed [31:0] box_high_y_ff;

   pib_pkg::cfg_type   bounds_in;
   pib_pkg::cfg_type   bounds_ff;
   logic signed [33:0] radius_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff      <= pib_pkg::RST_TIME_STEP;
         max_speed_ff      <= pib_pkg::RST_MAX_SPEED;
         attenuation_ff    <= pib_pkg::RST_ATTENUATION;
         support_radius_ff <= pib_pkg::RST_SUPPORT_RADIUS;
         box_low_x_ff      <= pib_pkg::RST_BOX_LOW_X;
         box_low_y_ff      <= pib_pkg::RST_BOX_LOW_Y;
         box_high_x_ff     <= pib_pkg::RST_BOX_HIGH_X;
         box_high_y_ff     <= pib_pkg::RST_BOX_HIGH_Y;
      end else if (csr_wr_en) begin
         case (pib_pkg::csr_index_type'(csr_index))
            pib_pkg::REG_TIME_STEP:      time_step_ff      <= csr_wdata[16:0];
            pib_pkg::REG_MAX_SPEED:      max_speed_ff      <= csr_wdata[30:0];
            pib_pkg::REG_ATTENUATION:    attenuation_ff    <= csr_wdata[16:0];
            pib_pkg::REG_SUPPORT_RADIUS: support_radius_ff <= csr_wdata[30:0];
            pib_pkg::REG_BOX_LOW_X:      box_low_x_ff      <= $signed(csr_wdata);
            pib_pkg::REG_BOX_LOW_Y:      box_low_y_ff      <= $signed(csr_wdata);
            pib_pkg::REG_BOX_HIGH_X:     box_high_x_ff     <= $signed(csr_wdata);
            pib_pkg::REG_BOX_HIGH_Y:     box_high_y_ff     <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      radius_ext             = $signed({3'd0, support_radius_ff});
      bounds_in              = '0;
      bounds_in.time_step    = time_step_ff;
      bounds_in.max_speed    = max_speed_ff;
      bounds_in.attenuation  = attenuation_ff;
      bounds_in.box_low_x    = box_low_x_ff;
      bounds_in.box_low_y    = box_low_y_ff;
      bounds_in.wall_low_x   = $signed({box_low_x_ff[31], box_low_x_ff})
                               + $signed({2'd0, support_radius_ff});
      bounds_in.wall_low_y   = $signed({box_low_y_ff[31], box_low_y_ff})
                               + $signed({2'd0, support_radius_ff});
      bounds_in.wall_high_x  = $signed({box_high_x_ff[31], box_high_x_ff})
                               - $signed({2'd0, support_radius_ff});
      bounds_in.wall_high_y  = $signed({box_high_y_ff[31], box_high_y_ff})
                               - $signed({2'd0, support_radius_ff});
      bounds_in.clamp_low_x  = $signed({{2{box_low_x_ff[31]}}, box_low_x_ff})
                               + radius_ext + pib_pkg::EDGE_EPS_W;
      bounds_in.clamp_low_y  = $signed({{2{box_low_y_ff[31]}}, box_low_y_ff})
                               + radius_ext + pib_pkg::EDGE_EPS_W;
      bounds_in.clamp_high_x = $signed({{2{box_high_x_ff[31]}}, box_high_x_ff})
                               - (radius_ext + pib_pkg::EDGE_EPS_W);
      bounds_in.clamp_high_y = $signed({{2{box_high_y_ff[31]}}, box_high_y_ff})
                               - (radius_ext + pib_pkg::EDGE_EPS_W);
   end

   // bounds are a registered copy that follows the registers in the next cycle
   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign cfg = bounds_ff;

endmodule

// ===== verif/particle_integrate_bound_bin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_integrate_bound_bin_checker
// Watches the request, response and csr ports of the particle step block,
// works out each particle's update in order and compares it field by field
// with what comes back. Mismatches are printed and counted for the top.
// ----------------------------------------------------------------------------
module particle_integrate_bound_bin_checker (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_vel_x,
   input  logic signed [31:0]                req_vel_y,
   input  logic signed [31:0]                req_acc_x,
   input  logic signed [31:0]                req_acc_y,

   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [31:0]                rsp_new_pos_x,
   input  logic signed [31:0]                rsp_new_pos_y,
   input  logic signed [31:0]                rsp_new_vel_x,
   input  logic signed [31:0]                rsp_new_vel_y,
   input  logic [15:0]                       rsp_cell_index,
   input  logic                              rsp_wall_hit,

   input  logic                              csr_wr_en,
   input  logic [pib_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pib_pkg::CSR_DATA_W-1:0]    csr_wdata,

   output int                                error_count,
   output int                                updates_pending,
   output int                                updates_checked,
   output int                                wall_hits_seen
);

   localparam longint Q_MIN = -64'sd2147483648;
   localparam longint Q_MAX = 64'sd2147483647;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [15:0]        cell_index;
      logic               wall_hit;
   } particle_update_type;

   logic [16:0]        step_ff;
   logic [30:0]        speed_limit_ff;
   logic [16:0]        damping_ff;
   logic [30:0]        margin_ff;
   logic signed [31:0] wall_lo_ff [2];
   logic signed [31:0] wall_hi_ff [2];

   particle_update_type expected_updates [$];

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      longint m;
      m = (v < hi) ? v : hi;
      return (lo > m) ? lo : m;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic particle_update_type integrate_particle(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] vx, input logic signed [31:0] vy,
      input logic signed [31:0] ax, input logic signed [31:0] ay);
      longint              pos [2];
      longint              vel [2];
      longint              acc [2];
      longint              lo [2];
      longint              hi [2];
      longint              npos [2];
      longint              dt, vmax, margin, damp, col, row, idx;
      logic                hit;
      particle_update_type res;
      pos[0] = longint'(px);  pos[1] = longint'(py);
      vel[0] = longint'(vx);  vel[1] = longint'(vy);
      acc[0] = longint'(ax);  acc[1] = longint'(ay);
      lo[0] = longint'(wall_lo_ff[0]);  lo[1] = longint'(wall_lo_ff[1]);
      hi[0] = longint'(wall_hi_ff[0]);  hi[1] = longint'(wall_hi_ff[1]);
      dt     = longint'(step_ff);
      vmax   = longint'(speed_limit_ff);
      margin = longint'(margin_ff);
      damp   = longint'(damping_ff);
      hit    = 1'b0;
      for (int j = 0; j < 2; j++) begin
         vel[j] = clip(vel[j] + ((acc[j] * dt) >>> 16), -vmax, vmax);
         pos[j] = pos[j] + ((vel[j] * dt) >>> 16);
      end
      // low walls are tested first, so a high wall in reach wins the sign
      for (int j = 0; j < 2; j++) begin
         if (pos[j] < lo[j] + margin) begin
            vel[j] = magnitude(vel[j]);
            hit    = 1'b1;
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (pos[j] > hi[j] - margin) begin
            vel[j] = -magnitude(vel[j]);
            hit    = 1'b1;
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (hit) begin
            vel[j] = (vel[j] * damp) >>> 16;
         end
         // lower bound wins on an inverted or too narrow box
         npos[j] = clip(pos[j], lo[j] + margin + pib_pkg::EDGE_EPS,
                        hi[j] - (margin + pib_pkg::EDGE_EPS));
         npos[j] = clip(npos[j], Q_MIN, Q_MAX);
         vel[j]  = clip(vel[j], -vmax, vmax);
      end
      col = (npos[0] - lo[0]) >>> pib_pkg::CELL_SHIFT;
      row = (npos[1] - lo[1]) >>> pib_pkg::CELL_SHIFT;
      idx = row * pib_pkg::GRID_COLS + col;
      res.pos_x      = 32'(npos[0]);
      res.pos_y      = 32'(npos[1]);
      res.vel_x      = 32'(vel[0]);
      res.vel_y      = 32'(vel[1]);
      res.cell_index = 16'(idx);
      res.wall_hit   = hit;
      return res;
   endfunction

   task automatic report_failure(input string msg);
      $display("%0t ns particle %0d: %s", $time, updates_checked, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      particle_update_type want;
      if (reset) begin
         expected_updates.delete();
         step_ff        <= pib_pkg::RST_TIME_STEP;
         speed_limit_ff <= pib_pkg::RST_MAX_SPEED;
         damping_ff     <= pib_pkg::RST_ATTENUATION;
         margin_ff      <= pib_pkg::RST_SUPPORT_RADIUS;
         wall_lo_ff[0]  <= pib_pkg::RST_BOX_LOW_X;
         wall_lo_ff[1]  <= pib_pkg::RST_BOX_LOW_Y;
         wall_hi_ff[0]  <= pib_pkg::RST_BOX_HIGH_X;
         wall_hi_ff[1]  <= pib_pkg::RST_BOX_HIGH_Y;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               report_failure("result returned with no particle in flight");
            end else begin
               want = expected_updates.pop_front();
               compare_field("new_pos_x", longint'(rsp_new_pos_x), longint'(want.pos_x));
               compare_field("new_pos_y", longint'(rsp_new_pos_y), longint'(want.pos_y));
               compare_field("new_vel_x", longint'(rsp_new_vel_x), longint'(want.vel_x));
               compare_field("new_vel_y", longint'(rsp_new_vel_y), longint'(want.vel_y));
               compare_field("cell_index", longint'(rsp_cell_index),
                             longint'(want.cell_index));
               compare_field("wall_hit", longint'(rsp_wall_hit), longint'(want.wall_hit));
               if (want.wall_hit) begin
                  wall_hits_seen++;
               end
            end
            updates_checked++;
         end
         // an item taken on the same edge as a csr write still sees the old value
         if (req_valid && req_ready) begin
            expected_updates.push_back(integrate_particle(req_pos_x, req_pos_y,
               req_vel_x, req_vel_y, req_acc_x, req_acc_y));
         end
         if (csr_wr_en) begin
            case (pib_pkg::csr_index_type'(csr_index))
               pib_pkg::REG_TIME_STEP:      step_ff        <= csr_wdata[16:0];
               pib_pkg::REG_MAX_SPEED:      speed_limit_ff <= csr_wdata[30:0];
               pib_pkg::REG_ATTENUATION:    damping_ff     <= csr_wdata[16:0];
               pib_pkg::REG_SUPPORT_RADIUS: margin_ff      <= csr_wdata[30:0];
               pib_pkg::REG_BOX_LOW_X:      wall_lo_ff[0]  <= csr_wdata;
               pib_pkg::REG_BOX_LOW_Y:      wall_lo_ff[1]  <= csr_wdata;
               pib_pkg::REG_BOX_HIGH_X:     wall_hi_ff[0]  <= csr_wdata;
               pib_pkg::REG_BOX_HIGH_Y:     wall_hi_ff[1]  <= csr_wdata;
               default: ;
            endcase
         end
      end
      updates_pending <= expected_updates.size();
   end

endmodule

// ===== verif/particle_integrate_bound_bin_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_integrate_bound_bin_tb
// Drives particles through the integrate, wall bound and binning pipeline
// under a series of box and speed settings, with random gaps on both sides
// and long result hold-offs; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module particle_integrate_bound_bin_tb;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_CYCLES     = 80;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      logic [16:0]        dt;
      logic [30:0]        vmax;
      logic [16:0]        att;
      logic [30:0]        margin;
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
   } box_settings_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic signed [31:0]              req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic signed [31:0]              req_acc_x, req_acc_y;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [31:0]              rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic [15:0]                     rsp_cell_index;
   logic                            rsp_wall_hit;
   logic                            csr_wr_en;
   logic [pib_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pib_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int               error_count;
   int               updates_pending;
   int               updates_checked;
   int               wall_hits_seen;
   int               cycle_count;
   int               particles_sent;
   int               settings_applied;
   int               stall_cycles;
   int               hold_offs_done;
   int               hold_offs_asked;
   bit               idle_on;
   box_settings_type cur_cfg;

   particle_integrate_bound_bin u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_acc_x      (req_acc_x),
      .req_acc_y      (req_acc_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_pos_x  (rsp_new_pos_x),
      .rsp_new_pos_y  (rsp_new_pos_y),
      .rsp_new_vel_x  (rsp_new_vel_x),
      .rsp_new_vel_y  (rsp_new_vel_y),
      .rsp_cell_index (rsp_cell_index),
      .rsp_wall_hit   (rsp_wall_hit),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   particle_integrate_bound_bin_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_acc_x       (req_acc_x),
      .req_acc_y       (req_acc_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_pos_x   (rsp_new_pos_x),
      .rsp_new_pos_y   (rsp_new_pos_y),
      .rsp_new_vel_x   (rsp_new_vel_x),
      .rsp_new_vel_y   (rsp_new_vel_y),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_wall_hit    (rsp_wall_hit),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .updates_pending (updates_pending),
      .updates_checked (updates_checked),
      .wall_hits_seen  (wall_hits_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
         updates_pending);
      $display("particle_integrate_bound_bin_tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) begin
         stall_cycles++;
      end
   end

   // result side: random back-pressure, or one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_done < hold_offs_asked) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_offs_done++;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 37);
         end
      end
   end

   function automatic longint pick(input longint lo, input longint hi);
      longint unsigned span, r;
      if (hi <= lo) begin
         return lo;
      end
      span = hi - lo + 1;
      r    = {$urandom, $urandom};
      return lo + longint'(r % span);
   endfunction

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   task automatic send_particle(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] vx, input logic signed [31:0] vy,
      input logic signed [31:0] ax, input logic signed [31:0] ay);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_acc_x <= ax;
      req_acc_y <= ay;
      do @(posedge clock); while (!req_ready);
      particles_sent++;
   endtask

   // stop offering and let every particle in flight come back
   task automatic finish_burst();
      @(negedge clock);
      req_valid <= 1'b0;
      while (updates_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input pib_pkg::csr_index_type idx,
                            input logic [pib_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic apply_settings(input box_settings_type s);
      csr_write(pib_pkg::REG_TIME_STEP, 32'(s.dt));
      csr_write(pib_pkg::REG_MAX_SPEED, 32'(s.vmax));
      csr_write(pib_pkg::REG_ATTENUATION, 32'(s.att));
      csr_write(pib_pkg::REG_SUPPORT_RADIUS, 32'(s.margin));
      csr_write(pib_pkg::REG_BOX_LOW_X, s.lo_x);
      csr_write(pib_pkg::REG_BOX_LOW_Y, s.lo_y);
      csr_write(pib_pkg::REG_BOX_HIGH_X, s.hi_x);
      csr_write(pib_pkg::REG_BOX_HIGH_Y, s.hi_y);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_cfg = s;
      settings_applied++;
   endtask

   function automatic box_settings_type random_settings();
      box_settings_type s;
      longint           lo;
      s.dt     = 17'($urandom_range(0, 65536));
      s.vmax   = $urandom_range(1) ? 31'($urandom_range(0, 1 << 22)) : 31'($urandom);
      s.att    = 17'($urandom_range(0, 65536));
      s.margin = $urandom_range(3) ? 31'($urandom_range(0, 1 << 16)) : 31'($urandom);
      lo       = pick(-1073741824, 1073741824);
      s.lo_x   = sat32(lo);
      s.hi_x   = sat32(lo + pick(0, 1 << 20));
      lo       = pick(-1073741824, 1073741824);
      s.lo_y   = sat32(lo);
      s.hi_y   = sat32(lo + pick(0, 1 << 20));
      return s;
   endfunction

   // mostly particles in and around the box, some noise across all bits
   task automatic send_random_particle();
      logic signed [31:0] p [2];
      logic signed [31:0] v [2];
      logic signed [31:0] a [2];
      longint             lo, hi, vlim, margin, base;
      int                 kind;
      kind   = $urandom_range(99);
      vlim   = longint'(cur_cfg.vmax);
      margin = longint'(cur_cfg.margin);
      for (int j = 0; j < 2; j++) begin
         lo = (j == 0) ? longint'(cur_cfg.lo_x) : longint'(cur_cfg.lo_y);
         hi = (j == 0) ? longint'(cur_cfg.hi_x) : longint'(cur_cfg.hi_y);
         if (hi < lo) begin
            base = lo;
            lo   = hi;
            hi   = base;
         end
         a[j] = $signed($urandom) >>> $urandom_range(0, 31);
         if (kind < 15) begin
            p[j] = $urandom;
            v[j] = $urandom;
            a[j] = $urandom;
         end else if (kind < 50) begin
            p[j] = sat32(pick(lo, hi));
            v[j] = sat32(pick(-2 * vlim - 1, 2 * vlim + 1));
         end else if (kind < 85) begin
            base = $urandom_range(1) ? lo + margin : hi - margin;
            p[j] = $urandom_range(1) ? sat32(base + pick(-8, 8))
                                     : sat32(base + pick(-65536, 65536));
            v[j] = sat32(pick(-2 * vlim - 1, 2 * vlim + 1));
         end else begin
            p[j] = sat32(pick(lo, hi));
            v[j] = $urandom_range(1) ? sat32(vlim + pick(-2, 2)) : sat32(-vlim + pick(-2, 2));
         end
      end
      send_particle(p[0], p[1], v[0], v[1], a[0], a[1]);
   endtask

   initial begin
      box_settings_type plan [$];
      req_valid       = 1'b0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_vel_x       = '0;
      req_vel_y       = '0;
      req_acc_x       = '0;
      req_acc_y       = '0;
      csr_wr_en       = 1'b0;
      csr_index       = pib_pkg::REG_TIME_STEP;
      csr_wdata       = '0;
      reset           = 1'b1;
      idle_on         = 1'b1;
      hold_offs_asked = 0;
      cur_cfg         = '{pib_pkg::RST_TIME_STEP, pib_pkg::RST_MAX_SPEED,
                          pib_pkg::RST_ATTENUATION, pib_pkg::RST_SUPPORT_RADIUS,
                          pib_pkg::RST_BOX_LOW_X, pib_pkg::RST_BOX_LOW_Y,
                          pib_pkg::RST_BOX_HIGH_X, pib_pkg::RST_BOX_HIGH_Y};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // unit box after reset: field extremes, exact wall thresholds, clamps
      send_particle(0, 0, 0, 0, 0, 0);
      send_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF);
      send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000);
      send_particle(32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                    32'hAAAAAAAA, 32'hAAAAAAAA);
      send_particle(32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
                    32'h55555555, 32'h55555555);
      send_particle(32768, 32768, 0, 0, 0, 0);
      send_particle(1638, 1637, 0, 0, 0, 0);
      send_particle(63898, 63899, 0, 0, 0, 0);
      send_particle(32768, 32768, 3 * 655360, -3 * 655360, 0, 0);
      send_particle(1000, 32768, -65536, 0, 0, 0);
      send_particle(32768, 65000, 0, 65536, 0, 0);
      send_particle(32768, 32768, 0, 0, 32'h7FFFFFFF, 32'h80000000);
      send_particle(-10000000, 10000000, 1000, -1000, 0, 0);
      finish_burst();

      // margin wider than half the box: both walls on each axis in reach
      apply_settings('{17'd655, 31'd655360, 17'd58982, 31'd40000, 0, 0, 65536, 65536});
      send_particle(32768, 32768, 65536, -65536, 0, 0);
      send_particle(32768, 32768, -65536, 65536, 0, 0);
      send_particle(0, 65536, 100, 100, -5000, 5000);
      finish_burst();

      // inverted box
      apply_settings('{17'd655, 31'd655360, 17'd58982, 31'd500,
                       100000, 100000, -100000, -100000});
      send_particle(0, 0, 0, 0, 0, 0);
      send_particle(200000, -200000, 65536, -65536, 0, 0);
      send_particle(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0);
      finish_burst();

      // clamp bounds past the 32 bit range, steps beyond one
      apply_settings('{17'd131071, 31'h7FFFFFFF, 17'd131071, 31'h7FFFFFFF,
                       32'h40000000, 32'h80000000, 32'h7FFFFFFF, 32'hC0000000});
      send_particle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000);
      send_particle(0, 0, 0, 0, 0, 0);
      send_particle(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF);
      finish_burst();

      plan.push_back('{17'd655, 31'd655360, 17'd58982, 31'd1638, 0, 0, 262144, 262144});
      plan.push_back('{17'd4096, 31'd1310720, 17'd32768, 31'd4096, 0, 0, 262144, 262144});
      plan.push_back('{17'd65536, 31'h7FFFFFFF, 17'd65536, 31'd0,
                       32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
      plan.push_back('{17'd0, 31'd0, 17'd0, 31'd0, 0, 0, 0, 0});
      plan.push_back('{17'd131071, 31'd1048576, 17'd131071, 31'd4096,
                       -65536, -65536, 65536, 65536});
      plan.push_back('{17'd655, 31'd655360, 17'd58982, 31'd500,
                       100000, 100000, -100000, -100000});
      plan.push_back('{17'd30000, 31'd655360, 17'd58982, 31'h7FFFFFFF, 0, 0, 65536, 65536});
      plan.push_back('{17'd655, 31'd655360, 17'd58982, 31'd1638,
                       -262144, -262144, -4096, -4096});
      repeat (4) plan.push_back(random_settings());

      foreach (plan[k]) begin
         apply_settings(plan[k]);
         // the second setting runs with no random gaps on either side
         idle_on = (k != 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (k < 2 && i == 30) begin
               hold_offs_asked++;
            end
            if (k == 3 && i == 50) begin
               finish_burst();
            end
            send_random_particle();
         end
         finish_burst();
      end

      $display("%0d particles under %0d csr settings, %0d results checked, %0d hit a wall",
         particles_sent, settings_applied, updates_checked, wall_hits_seen);
      $display("request side stalled for %0d cycles across %0d long result hold-offs",
         stall_cycles, hold_offs_done);
      if (error_count == 0) begin
         $display("particle_integrate_bound_bin_tb: PASS");
      end else begin
         $display("particle_integrate_bound_bin_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pib_pkg.sv
rtl/pib_csr.sv
rtl/particle_integrate_bound_bin.sv
verif/particle_integrate_bound_bin_checker.sv
verif/particle_integrate_bound_bin_tb.sv
